[hw/rtl/ssfs_pkg.sv]
// ----------------------------------------------------------------------------
// ssfs_pkg
// Shared types, constants and the character-to-segment table for the
// two-wire seven-segment frame sender.
// ----------------------------------------------------------------------------
package ssfs_pkg;

    localparam int DIGITS = 4;      // digits sent per show frame (1..6)
    localparam int LANES  = 4;      // character ports / digit store depth

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_SHOW   = 2'd1,
        CMD_BRIGHT = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    localparam logic [7:0] ADDR_AUTO_BYTE = 8'h40;
    localparam logic [7:0] ADDR_DIGIT0    = 8'hC0;
    localparam logic [7:0] DIGIT_OFFSET   = 8'h80;
    localparam logic [7:0] BRIGHT_MAX     = 8'h07;

    // line levels and status after one step
    typedef struct packed {
        logic clock_line;
        logic data_line;
        logic data_driven;
        logic busy_res;
        logic accepted;
    } t_result;

    function automatic logic [7:0] seg_code(input logic [7:0] ch);
        logic [7:0] code;
        case (ch)
            "0": code = 8'h3F;  "1": code = 8'h06;  "2": code = 8'h5B;
            "3": code = 8'h4F;  "4": code = 8'h66;  "5": code = 8'h6D;
            "6": code = 8'h7D;  "7": code = 8'h07;  "8": code = 8'h7F;
            "9": code = 8'h6F;
            "A": code = 8'h77;  "C": code = 8'h39;  "E": code = 8'h79;
            "F": code = 8'h71;  "G": code = 8'h3D;  "H": code = 8'h76;
            "I": code = 8'h06;  "J": code = 8'h1E;  "K": code = 8'h75;
            "L": code = 8'h38;  "N": code = 8'h37;  "O": code = 8'h3F;
            "P": code = 8'h73;  "R": code = 8'h31;  "S": code = 8'h6D;
            "b": code = 8'h7C;  "c": code = 8'h58;  "d": code = 8'h5E;
            "g": code = 8'h6F;  "h": code = 8'h74;  "i": code = 8'h04;
            "n": code = 8'h54;  "o": code = 8'h5C;  "q": code = 8'h67;
            "r": code = 8'h50;  "t": code = 8'h78;  "u": code = 8'h1C;
            "y": code = 8'h6E;
            "-": code = 8'h40;  " ": code = 8'h00;  ":": code = 8'h80;
            ".": code = 8'hFF;  "^": code = 8'h63;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

[hw/rtl/ssfs_lane.sv]
// ----------------------------------------------------------------------------
// ssfs_lane
// One character lane: segment lookup plus the fixed 0x80 offset.
// ----------------------------------------------------------------------------
module ssfs_lane
    import ssfs_pkg::*;
(
    input  logic [7:0] i_char,
    output logic [7:0] o_byte
);

    // 8-bit wrap on the add is intended
    assign o_byte = seg_code(i_char) + DIGIT_OFFSET;

endmodule

[hw/rtl/ssfs_seq.sv]
// ----------------------------------------------------------------------------
// ssfs_seq
// Line sequencer: merges the lane bytes into the digit store and walks the
// start / byte / ack / stop transitions, one per tick word.
// ----------------------------------------------------------------------------
module ssfs_seq
    import ssfs_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,          // a word is taken this cycle
    input  t_cmd            i_cmd,
    input  logic [7:0]      i_lane_byte [LANES],
    input  logic [7:0]      i_level,
    input  logic            i_display_on,
    output t_result         o_res            // line state after this word
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_START_A, PH_START_B, PH_BIT_DATA, PH_BIT_HI, PH_BIT_LO,
        PH_ACK_REL, PH_ACK_HI, PH_ACK_LO, PH_STOP_A, PH_STOP_B, PH_STOP_C
    } t_phase;

    localparam logic [3:0] LAST_BYTE = 4'(DIGITS + 2);

    t_phase     r_phase,  n_phase;
    logic       r_bright, n_bright;      // frame kind: 1 = brightness
    logic [7:0] r_shift,  n_shift;
    logic [3:0] r_bits,   n_bits;
    logic [2:0] r_idx,    n_idx;
    logic       r_clk,    n_clk;
    logic       r_dat,    n_dat;
    logic       r_drv,    n_drv;
    logic       n_acc;
    logic       store_we;
    logic [7:0] r_store [LANES];         // undefined until first show

    logic [2:0] idx_sel;
    logic [2:0] digit_pos;
    logic [7:0] show_byte;
    logic [7:0] bright_lvl;
    logic [7:0] bright_byte;

    // byte of the show sequence at idx_sel
    always_comb begin
        digit_pos = idx_sel - 3'd2;
        if (idx_sel == 3'd0) begin
            show_byte = ADDR_AUTO_BYTE;
        end else if (idx_sel == 3'd1) begin
            show_byte = ADDR_DIGIT0;
        end else if (digit_pos < 3'(LANES)) begin
            show_byte = r_store[digit_pos[1:0]];
        end else begin
            show_byte = DIGIT_OFFSET;
        end
    end

    assign bright_lvl  = (i_level > BRIGHT_MAX) ? BRIGHT_MAX : i_level;
    assign bright_byte = {4'b1000, i_display_on, bright_lvl[2:0]};

    always_comb begin
        n_phase  = r_phase;
        n_bright = r_bright;
        n_shift  = r_shift;
        n_bits   = r_bits;
        n_idx    = r_idx;
        n_clk    = r_clk;
        n_dat    = r_dat;
        n_drv    = r_drv;
        n_acc    = 1'b0;
        store_we = 1'b0;
        idx_sel  = r_idx;

        unique case (i_cmd)
            CMD_TICK: begin
                unique case (r_phase)
                    PH_START_A: begin
                        n_clk = 1'b1; n_dat = 1'b0; n_drv = 1'b1;
                        n_phase = PH_START_B;
                    end
                    PH_START_B: begin
                        n_clk = 1'b0;
                        if (!r_bright) n_shift = show_byte;
                        n_bits  = 4'd0;
                        n_phase = PH_BIT_DATA;
                    end
                    PH_BIT_DATA: begin
                        n_dat   = r_shift[0];
                        n_phase = PH_BIT_HI;
                    end
                    PH_BIT_HI: begin
                        n_clk   = 1'b1;
                        n_phase = PH_BIT_LO;
                    end
                    PH_BIT_LO: begin
                        n_clk   = 1'b0;
                        n_shift = r_shift >> 1;
                        n_bits  = r_bits + 4'd1;
                        n_phase = (n_bits >= 4'd8) ? PH_ACK_REL : PH_BIT_DATA;
                    end
                    PH_ACK_REL: begin
                        n_drv = 1'b0; n_dat = 1'b1;
                        n_phase = PH_ACK_HI;
                    end
                    PH_ACK_HI: begin
                        n_clk   = 1'b1;
                        n_phase = PH_ACK_LO;
                    end
                    PH_ACK_LO: begin
                        n_clk = 1'b0; n_drv = 1'b1; n_dat = 1'b1;
                        n_idx   = r_idx + 3'd1;
                        idx_sel = n_idx;
                        if (!r_bright && n_idx >= 3'd2 && {1'b0, n_idx} < LAST_BYTE) begin
                            n_shift = show_byte;
                            n_bits  = 4'd0;
                            n_phase = PH_BIT_DATA;
                        end else begin
                            n_phase = PH_STOP_A;
                        end
                    end
                    PH_STOP_A: begin
                        n_dat   = 1'b0;
                        n_phase = PH_STOP_B;
                    end
                    PH_STOP_B: begin
                        n_clk   = 1'b1;
                        n_phase = PH_STOP_C;
                    end
                    PH_STOP_C: begin
                        n_dat = 1'b1;
                        // show frame: command byte done, digit frame follows
                        n_phase = (!r_bright && r_idx == 3'd1) ? PH_START_A : PH_IDLE;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
            CMD_SHOW: begin
                if (r_phase == PH_IDLE) begin
                    store_we = 1'b1;
                    n_bright = 1'b0;
                    n_idx    = 3'd0;
                    n_bits   = 4'd0;
                    n_phase  = PH_START_A;
                    n_acc    = 1'b1;
                end
            end
            CMD_BRIGHT: begin
                if (r_phase == PH_IDLE) begin
                    n_shift  = bright_byte;
                    n_bright = 1'b1;
                    n_idx    = 3'd0;
                    n_bits   = 4'd0;
                    n_phase  = PH_START_A;
                    n_acc    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_bright <= 1'b0;
            r_shift  <= 8'h00;
            r_bits   <= 4'd0;
            r_idx    <= 3'd0;
            r_clk    <= 1'b1;
            r_dat    <= 1'b1;
            r_drv    <= 1'b1;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_bright <= n_bright;
            r_shift  <= n_shift;
            r_bits   <= n_bits;
            r_idx    <= n_idx;
            r_clk    <= n_clk;
            r_dat    <= n_dat;
            r_drv    <= n_drv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && store_we) begin
            r_store <= i_lane_byte;
        end
    end

    assign o_res = '{clock_line:  n_clk,
                     data_line:   n_dat,
                     data_driven: n_drv,
                     busy_res:    (n_phase != PH_IDLE),
                     accepted:    n_acc};

endmodule

[hw/rtl/seven_segment_serial_frame_sender_core.sv]
// ----------------------------------------------------------------------------
// seven_segment_serial_frame_sender_core
// Two-wire frame sender for a four-digit seven-segment display.
// ----------------------------------------------------------------------------
// Every input word produces exactly one output word. A tick word (command 0)
// advances the two-wire line by one transition; a show word (command 1) loads
// the four characters, which four parallel lanes translate to segment bytes
// (+0x80) in the same cycle; a brightness word (command 2) loads the control
// byte. Show and brightness words are only taken while the line is idle and
// report accepted=1; otherwise they are dropped with accepted=0. The output
// word carries the clock/data levels, the data drive flag and busy after the
// word has been applied. Throughput is one word per clock: the sequencer
// state updates in the accept cycle and the result goes into a one-word
// output register, so a new word is taken whenever that register is empty or
// is being drained in the same cycle. o_out_valid is registered and rises in
// the cycle after the accept.
// ----------------------------------------------------------------------------
module seven_segment_serial_frame_sender_core
    import ssfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_command,
    input  logic [7:0] i_char0,
    input  logic [7:0] i_char1,
    input  logic [7:0] i_char2,
    input  logic [7:0] i_char3,
    input  logic [7:0] i_level,
    input  logic       i_display_on,

    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_clock_line,
    output logic       o_data_line,
    output logic       o_data_driven,
    output logic       o_busy_res,
    output logic       o_accepted
);

    logic       step;
    logic [7:0] chars     [LANES];
    logic [7:0] lane_byte [LANES];
    t_result    seq_res;
    t_result    r_res;
    logic       r_out_valid;

    assign chars[0] = i_char0;
    assign chars[1] = i_char1;
    assign chars[2] = i_char2;
    assign chars[3] = i_char3;

    // Output register frees up in the same cycle it is drained.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign step       = i_in_valid && o_in_ready;

    // Character lanes; digits past DIGITS see NUL and come out as 0x80.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic [7:0] lane_char;
        if (g < DIGITS) begin : g_used
            assign lane_char = chars[g];
        end else begin : g_blank
            assign lane_char = 8'h00;
        end
        ssfs_lane u_lane (
            .i_char (lane_char),
            .o_byte (lane_byte[g])
        );
    end

    // Sequencer also merges the lane bytes into its digit store.
    ssfs_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_cmd        (t_cmd'(i_command)),
        .i_lane_byte  (lane_byte),
        .i_level      (i_level),
        .i_display_on (i_display_on),
        .o_res        (seq_res)
    );

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= seq_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_clock_line  = r_res.clock_line;
    assign o_data_line   = r_res.data_line;
    assign o_data_driven = r_res.data_driven;
    assign o_busy_res    = r_res.busy_res;
    assign o_accepted    = r_res.accepted;

    // A taken command always starts a sequence.
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.accepted |-> r_res.busy_res)
        else $error("accepted command without busy");

    // Data is only released during the ack slot, and then reads high.
    a_release_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.data_driven |-> r_res.data_line && r_res.busy_res)
        else $error("released data line not high or not busy");

    // Only show or brightness words can be accepted.
    a_acc_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && seq_res.accepted |-> (i_command == CMD_SHOW || i_command == CMD_BRIGHT))
        else $error("accepted flag on a non-command word");

endmodule
